FILE: sv/eapmd_pkg.sv
`default_nettype none

package eapmd_pkg;

  // encoder wrap
  localparam int COUNTS_PER_TURN = 1600;
  localparam int COUNT_HALF      = COUNTS_PER_TURN / 2;

  // error window length default
  localparam int WINDOW_LEN_DEF = 5;

  // field widths
  localparam int COUNT_W    = 11;
  localparam int ERR_W      = 10;
  localparam int DUTY_W     = 7;
  localparam int GAIN_W     = 8;
  localparam int TARGET_W   = 9;
  localparam int SCALE_W    = 4;
  localparam int NUM10_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // divide by ten: q = (n * 52429) >> 19, exact for n below 43690
  localparam int RECIP10       = 52429;
  localparam int RECIP10_SHIFT = 19;
  localparam int Q10_W         = 11;

  // error saturation
  localparam int ERR_MAX = 511;
  localparam int ERR_MIN = -512;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd5;

  // register reset values
  localparam logic [GAIN_W-1:0]   KP_RST     = 8'd15;
  localparam logic [GAIN_W-1:0]   KI_RST     = 8'd4;
  localparam logic [GAIN_W-1:0]   KD_RST     = 8'd14;
  localparam logic [TARGET_W-1:0] TARGET_RST = 9'd0;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 4'd3;
  localparam logic [DUTY_W-1:0]   LIMIT_RST  = 7'd100;

endpackage

`default_nettype wire

FILE: sv/encoder_angle_pid_motor_drive_core.sv
`default_nettype none

// channel | handshake           | payload
// --------+---------------------+---------------------------------------------
// in      | in_valid / in_ready | phase_a, phase_b
// out     | out_valid/out_ready | motor_in1, motor_in2, pwm_duty,
//         |                     | position_count, angle_error
// cfg     | cfg_we (no wait)    | cfg_index, cfg_data
//
// one word accepted per cycle while the pipeline advances, one result word per input word
// six register stages carry each word from the input accept to out_valid, the first
// loaded at accept and the last holding the result word together with out_valid
// the whole pipeline advances together; it holds only while out_valid waits on out_ready
// rst is synchronous: pipeline empty, count, phases and error window zero, registers at defaults

module encoder_angle_pid_motor_drive_core #(
  parameter int WINDOW_LEN = eapmd_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                phase_a,
  input  wire logic                                phase_b,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     motor_in1,
  output logic                                     motor_in2,
  output logic [eapmd_pkg::DUTY_W-1:0]             pwm_duty,
  output logic signed [eapmd_pkg::COUNT_W-1:0]     position_count,
  output logic signed [eapmd_pkg::ERR_W-1:0]       angle_error,
  input  wire logic                                cfg_we,
  input  wire logic [eapmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [eapmd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import eapmd_pkg::*;

  localparam int HIST_LEN = WINDOW_LEN - 1;
  localparam int SUM_W    = ERR_W + $clog2(WINDOW_LEN);
  localparam int DIFF_W   = ERR_W + 1;
  localparam int PE_W     = GAIN_W + 1 + ERR_W;
  localparam int DE_W     = GAIN_W + 1 + DIFF_W;
  localparam int IE_W     = GAIN_W + 1 + SUM_W;
  localparam int DW       = 23 + $clog2(WINDOW_LEN);
  // small quotient path: magnitudes below WINDOW_LEN*128
  localparam int SMALL_W  = $clog2(WINDOW_LEN * 128);
  localparam int RDIV     = (65536 + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int SPROD_W  = SMALL_W + 17;

  // configuration registers
  logic [GAIN_W-1:0]          kp;
  logic [GAIN_W-1:0]          ki;
  logic [GAIN_W-1:0]          kd;
  logic signed [TARGET_W-1:0] target_angle;
  logic [SCALE_W-1:0]         angle_scale_tenths;
  logic [DUTY_W-1:0]          duty_limit;

  // loop state
  logic                      prev_a;
  logic                      prev_b;
  logic signed [COUNT_W-1:0] count;
  logic signed [ERR_W-1:0]   hist [HIST_LEN];

  // stage valids
  logic v1, v2, v3, v4, v5;
  logic adv;

  // stage payload
  logic signed [COUNT_W-1:0] c1, c2, c3, c4, c5;
  logic signed [NUM10_W-1:0] n2;
  logic [Q10_W-1:0]          q3;
  logic                      neg3;
  logic signed [ERR_W-1:0]   e4, e5;
  logic signed [SUM_W-1:0]   s4;
  logic signed [DIFF_W-1:0]  d4;
  logic signed [PE_W-1:0]    pe5;
  logic signed [DE_W-1:0]    de5;
  logic signed [IE_W-1:0]    ie5;

  // combinational values
  logic signed [COUNT_W:0]   step_a, step_b, cnt_sum;
  logic signed [COUNT_W-1:0] count_next;
  logic signed [NUM10_W-1:0] num10_next;
  logic [NUM10_W-1:0]        n2_mag;
  logic [30:0]               q_prod;
  logic signed [ERR_W-1:0]   e_next;
  logic signed [SUM_W-1:0]   sum_next;
  logic signed [DIFF_W-1:0]  diff_next;
  logic signed [DW-1:0]      drive;
  logic [DW-1:0]             drv_mag, cap_thr;
  logic [SPROD_W-1:0]        small_prod;
  logic                      in1_next, in2_next;
  logic [DUTY_W-1:0]         duty_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp                 <= KP_RST;
      ki                 <= KI_RST;
      kd                 <= KD_RST;
      target_angle       <= TARGET_RST;
      angle_scale_tenths <= SCALE_RST;
      duty_limit         <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:     kp                 <= cfg_data[GAIN_W-1:0];
        REG_KI:     ki                 <= cfg_data[GAIN_W-1:0];
        REG_KD:     kd                 <= cfg_data[GAIN_W-1:0];
        REG_TARGET: target_angle       <= cfg_data[TARGET_W-1:0];
        REG_SCALE:  angle_scale_tenths <= cfg_data[SCALE_W-1:0];
        REG_LIMIT:  duty_limit         <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // quadrature decode: A-edge rule then B-edge rule, then wrap
  always_comb begin
    step_a = '0;
    step_b = '0;
    if (phase_a != prev_a) begin
      step_a = (phase_b != phase_a) ? (COUNT_W+1)'(1) : -(COUNT_W+1)'(1);
    end
    if (phase_b != prev_b) begin
      step_b = (phase_a == phase_b) ? (COUNT_W+1)'(1) : -(COUNT_W+1)'(1);
    end
    cnt_sum = (COUNT_W+1)'(count) + step_a + step_b;
    if (cnt_sum > (COUNT_W+1)'(COUNT_HALF)) begin
      count_next = COUNT_W'(cnt_sum - (COUNT_W+1)'(COUNTS_PER_TURN));
    end else if (cnt_sum < -(COUNT_W+1)'(COUNT_HALF)) begin
      count_next = COUNT_W'(cnt_sum + (COUNT_W+1)'(COUNTS_PER_TURN));
    end else begin
      count_next = COUNT_W'(cnt_sum);
    end
  end

  // ten times the angle error
  assign num10_next = NUM10_W'(target_angle) * NUM10_W'(10)
                    - signed'(NUM10_W'(angle_scale_tenths)) * NUM10_W'(c1);

  // magnitude divided by ten through a reciprocal
  assign n2_mag = n2[NUM10_W-1] ? NUM10_W'(-n2) : NUM10_W'(n2);
  assign q_prod = 31'(n2_mag[NUM10_W-2:0]) * 31'(RECIP10);

  // restore sign, saturate, window sum and difference
  always_comb begin
    if (!neg3) begin
      e_next = (q3 > Q10_W'(ERR_MAX)) ? ERR_W'(ERR_MAX) : ERR_W'(q3);
    end else begin
      e_next = (q3 > Q10_W'(-ERR_MIN)) ? ERR_W'(ERR_MIN)
                                       : ERR_W'(-signed'({1'b0, q3}));
    end
    sum_next = SUM_W'(e_next);
    for (int i = 0; i < HIST_LEN; i++) begin
      sum_next = sum_next + SUM_W'(hist[i]);
    end
    diff_next = DIFF_W'(e_next) - DIFF_W'(hist[HIST_LEN-1]);
  end

  // drive, direction and capped duty
  always_comb begin
    drive   = (DW'(pe5) + DW'(de5)) * DW'(WINDOW_LEN) + DW'(ie5);
    drv_mag = drive[DW-1] ? DW'(-drive) : DW'(drive);
    cap_thr = DW'(WINDOW_LEN) * (DW'(duty_limit) + DW'(1));
    small_prod = SPROD_W'(drv_mag[SMALL_W-1:0]) * SPROD_W'(RDIV);
    in1_next  = 1'b0;
    in2_next  = 1'b0;
    duty_next = '0;
    if (e5 != '0) begin
      in1_next = drive < 0;
      in2_next = drive > 0;
      if (drv_mag >= cap_thr) begin
        duty_next = duty_limit;
      end else begin
        duty_next = DUTY_W'(small_prod >> 16);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
      prev_a    <= 1'b0;
      prev_b    <= 1'b0;
      count     <= '0;
      for (int i = 0; i < HIST_LEN; i++) begin
        hist[i] <= '0;
      end
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
      if (in_valid) begin
        prev_a <= phase_a;
        prev_b <= phase_b;
        count  <= count_next;
      end
      // error window shifts as each word leaves the divide stage
      if (v3) begin
        for (int i = 0; i < HIST_LEN - 1; i++) begin
          hist[i] <= hist[i+1];
        end
        hist[HIST_LEN-1] <= e_next;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      c1             <= count_next;
      c2             <= c1;
      n2             <= num10_next;
      c3             <= c2;
      q3             <= Q10_W'(q_prod >> RECIP10_SHIFT);
      neg3           <= n2[NUM10_W-1];
      c4             <= c3;
      e4             <= e_next;
      s4             <= sum_next;
      d4             <= diff_next;
      c5             <= c4;
      e5             <= e4;
      pe5            <= PE_W'(signed'({1'b0, kp})) * PE_W'(e4);
      de5            <= DE_W'(signed'({1'b0, kd})) * DE_W'(d4);
      ie5            <= IE_W'(signed'({1'b0, ki})) * IE_W'(s4);
      motor_in1      <= in1_next;
      motor_in2      <= in2_next;
      pwm_duty       <= duty_next;
      position_count <= c5;
      angle_error    <= e5;
    end
  end

endmodule

`default_nettype wire

FILE: sv/eapmd_checker.sv
`default_nettype none

module eapmd_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic                                motor_in1,
  input wire logic                                motor_in2,
  input wire logic [eapmd_pkg::DUTY_W-1:0]        pwm_duty,
  input wire logic signed [eapmd_pkg::COUNT_W-1:0] position_count,
  input wire logic signed [eapmd_pkg::ERR_W-1:0]  angle_error
);
  import eapmd_pkg::*;

  // a waiting result word is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // zero error stops the motor
  a_zero_err_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && angle_error == '0 |-> !motor_in1 && !motor_in2 && pwm_duty == '0)
    else $error("motor driven on zero error");

  // never both driver pins
  a_pins_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(motor_in1 && motor_in2))
    else $error("both driver pins high");

  // nonzero duty always has a direction
  a_duty_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && pwm_duty != '0 |-> motor_in1 || motor_in2)
    else $error("duty without direction");

  // count stays inside one turn
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position_count <= COUNT_W'(COUNT_HALF)
               && position_count >= -COUNT_W'(COUNT_HALF))
    else $error("position count outside wrap range");

endmodule

bind encoder_angle_pid_motor_drive_core eapmd_checker u_eapmd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .motor_in1      (motor_in1),
  .motor_in2      (motor_in2),
  .pwm_duty       (pwm_duty),
  .position_count (position_count),
  .angle_error    (angle_error)
);

`default_nettype wire

FILE: bench/drive_checker.sv
`timescale 1ns / 100ps

module drive_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 phase_a,
  input  logic                                 phase_b,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 motor_in1,
  input  logic                                 motor_in2,
  input  logic [eapmd_pkg::DUTY_W-1:0]         pwm_duty,
  input  logic signed [eapmd_pkg::COUNT_W-1:0] position_count,
  input  logic signed [eapmd_pkg::ERR_W-1:0]   angle_error,
  input  logic                                 cfg_we,
  input  logic [eapmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eapmd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                   pending,
  output int                                   fail_count
);
  import eapmd_pkg::*;

  localparam int WIN      = WINDOW_LEN_DEF;
  localparam int HIST     = WINDOW_LEN_DEF - 1;

  typedef struct packed {
    logic              in1;
    logic              in2;
    logic [DUTY_W-1:0]  duty;
    logic [COUNT_W-1:0] count;
    logic [ERR_W-1:0]   err;
  } drive_word_t;

  // register copies
  logic [GAIN_W-1:0]          gain_p, gain_i, gain_d;
  logic signed [TARGET_W-1:0] target;
  logic [SCALE_W-1:0]         scale;
  logic [DUTY_W-1:0]          duty_cap;

  // encoder and error window state
  logic last_a, last_b;
  int   enc_count;
  int   err_hist [HIST];

  drive_word_t drive_q [$];
  drive_word_t want;
  int          mism = 0;

  // one control tick: update the count, then form the error and the drive
  function automatic drive_word_t predict_drive(input logic a, input logic b);
    int          num10, err;
    longint      drive, mag, win_sum;
    drive_word_t w;
    w = '0;
    if (a != last_a) enc_count += (b != a) ? 1 : -1;
    last_a = a;
    if (b != last_b) enc_count += (a == b) ? 1 : -1;
    last_b = b;
    if (enc_count > COUNT_HALF) enc_count -= COUNTS_PER_TURN;
    if (enc_count < -COUNT_HALF) enc_count += COUNTS_PER_TURN;

    num10 = 10 * int'(target) - int'(scale) * enc_count;
    err = num10 / 10;
    if (err > ERR_MAX) err = ERR_MAX;
    if (err < ERR_MIN) err = ERR_MIN;

    if (err != 0) begin
      win_sum = err;
      for (int i = 0; i < HIST; i++) win_sum += err_hist[i];
      drive = WIN * longint'(gain_p) * err + longint'(gain_i) * win_sum
            + WIN * longint'(gain_d) * (err - err_hist[HIST-1]);
      if (drive > 0) begin
        w.in2 = 1'b1;
        mag = drive;
      end else if (drive < 0) begin
        w.in1 = 1'b1;
        mag = -drive;
      end else begin
        mag = 0;
      end
      mag = mag / WIN;
      w.duty = (mag > longint'(duty_cap)) ? duty_cap : mag[DUTY_W-1:0];
    end

    // window shifts on every tick, zero error included
    for (int i = 0; i < HIST - 1; i++) err_hist[i] = err_hist[i+1];
    err_hist[HIST-1] = err;

    w.count = enc_count[COUNT_W-1:0];
    w.err   = err[ERR_W-1:0];
    return w;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      mism++;
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gain_p    = KP_RST;
      gain_i    = KI_RST;
      gain_d    = KD_RST;
      target    = TARGET_RST;
      scale     = SCALE_RST;
      duty_cap  = LIMIT_RST;
      last_a    = 1'b0;
      last_b    = 1'b0;
      enc_count = 0;
      for (int i = 0; i < HIST; i++) err_hist[i] = 0;
      drive_q.delete();
    end else begin
      // register writes, unknown indexes dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:     gain_p   = cfg_data[GAIN_W-1:0];
          REG_KI:     gain_i   = cfg_data[GAIN_W-1:0];
          REG_KD:     gain_d   = cfg_data[GAIN_W-1:0];
          REG_TARGET: target   = cfg_data[TARGET_W-1:0];
          REG_SCALE:  scale    = cfg_data[SCALE_W-1:0];
          REG_LIMIT:  duty_cap = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end

      // result word against the oldest expectation
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          mism++;
          $error("result word with no expectation waiting");
        end else begin
          want = drive_q.pop_front();
          check_field("motor_in1", want.in1, motor_in1);
          check_field("motor_in2", want.in2, motor_in2);
          check_field("pwm_duty", want.duty, pwm_duty);
          check_field("position_count", $signed(want.count), position_count);
          check_field("angle_error", $signed(want.err), angle_error);
        end
      end

      if (in_valid && in_ready) drive_q.push_back(predict_drive(phase_a, phase_b));
    end
    pending    <= drive_q.size();
    fail_count <= mism;
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import eapmd_pkg::*;

  localparam int PHASES          = 9;
  localparam int WORDS_PER_PHASE = 150;
  localparam int TRAVEL_TOP      = COUNT_HALF + 40;
  localparam int LIMIT           = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid, in_ready;
  logic                         phase_a, phase_b;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         motor_in1, motor_in2;
  logic [DUTY_W-1:0]            pwm_duty;
  logic signed [COUNT_W-1:0]    position_count;
  logic signed [ERR_W-1:0]      angle_error;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  int                           pending, fail_count;

  int          cycle_count = 0;
  int          burst_left = 0;
  int          gray_pos = 0;
  int          tally = 0;
  int          peak = 0;
  int          words_sent = 0;
  int          settings_done = 0;
  logic [31:0] ready_pattern = '1;
  logic [31:0] ready_tick = '0;

  always #5 clk = ~clk;

  encoder_angle_pid_motor_drive_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .phase_a(phase_a), .phase_b(phase_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .motor_in1(motor_in1), .motor_in2(motor_in2), .pwm_duty(pwm_duty),
    .position_count(position_count), .angle_error(angle_error),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  drive_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .phase_a(phase_a), .phase_b(phase_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .motor_in1(motor_in1), .motor_in2(motor_in2), .pwm_duty(pwm_duty),
    .position_count(position_count), .angle_error(angle_error),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls: a 32-bit ready pattern indexed by the low tick bits, reshuffled when the low eight tick bits wrap
  always @(negedge clk) begin
    if (ready_tick[7:0] == 8'd0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= '1;
        1:       ready_pattern <= $urandom | 32'h1;
        2:       ready_pattern <= $urandom | $urandom | 32'h1;
        default: ready_pattern <= ($urandom & $urandom) | 32'h1;
      endcase
    end
    ready_tick <= ready_tick + 1;
    out_ready  <= ready_pattern[ready_tick[4:0]];
  end

  // one encoder word, sent in bursts with random gaps between them
  task automatic send_word(input logic a, input logic b);
    int idle_gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      idle_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      if (idle_gap != 0) begin
        in_valid <= 1'b0;
        repeat (idle_gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    phase_a  <= a;
    phase_b  <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // move the encoder to a quadrature position, tracking the net travel
  task automatic step_to(input int pos);
    int         delta;
    logic [1:0] code;
    pos   = pos & 3;
    delta = (pos - gray_pos) & 3;
    if (delta == 1) tally++;
    else if (delta == 3) tally--;
    if (tally > peak) peak = tally;
    gray_pos = pos;
    // forward order 00, 10, 11, 01 as {a, b}
    case (pos)
      0:       code = 2'b00;
      1:       code = 2'b10;
      2:       code = 2'b11;
      default: code = 2'b01;
    endcase
    send_word(code[1], code[0]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  // drain the pipe, then load every register
  task automatic apply_settings(input logic [8:0] p, input logic [8:0] i,
                                input logic [8:0] d, input logic [8:0] tgt,
                                input logic [8:0] sc, input logic [8:0] lim);
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_SCALE, sc);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_SPARE_LO, 9'($urandom_range(0, 511)));
    write_reg(REG_SPARE_HI, 9'($urandom_range(0, 511)));
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // register value: mostly within the useful range, sometimes any bit pattern
  function automatic logic [8:0] pick_setting(input logic [CFG_IDX_W-1:0] idx);
    int v;
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom_range(0, 511);
    end else begin
      case (idx)
        REG_TARGET: v = int'($urandom_range(0, 480)) - 240;
        REG_SCALE:  v = $urandom_range(1, 10);
        REG_LIMIT:  v = $urandom_range(0, 100);
        default:    v = $urandom_range(0, 255);
      endcase
    end
    return v[8:0];
  endfunction

  initial begin
    int pick, next_pos, heading;
    rst       = 1'b1;
    in_valid  = 1'b0;
    phase_a   = 1'b0;
    phase_b   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    heading   = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: still at zero error, a full forward quadrature cycle, reverse, double toggles
    step_to(0);
    step_to(1);
    step_to(2);
    step_to(3);
    step_to(0);
    step_to(3);
    step_to(2);
    step_to(0);
    step_to(2);
    step_to(2);

    // all gains zero: error without drive
    apply_settings(9'd0, 9'd0, 9'd0, 9'd0, 9'd10, 9'd100);
    step_to(gray_pos + 1);
    step_to(gray_pos + 1);
    step_to(gray_pos + 1);

    // scale zero makes the error equal the target; flush the window with zeros
    apply_settings(9'd0, 9'd1, 9'd0, 9'd0, 9'd0, 9'd100);
    repeat (4) step_to(gray_pos);
    // error of one with a drive below one count
    apply_settings(9'd0, 9'd1, 9'd0, 9'd1, 9'd0, 9'd100);
    step_to(gray_pos);
    // error of minus one cancels the window: zero drive, nonzero error
    apply_settings(9'd0, 9'd1, 9'd0, 9'h1FF, 9'd0, 9'd100);
    step_to(gray_pos);

    // largest gains, cap wide open then shut
    apply_settings(9'd255, 9'd255, 9'd255, 9'd255, 9'd15, 9'd127);
    step_to(gray_pos + 1);
    step_to(gray_pos + 1);
    apply_settings(9'd255, 9'd255, 9'd255, 9'h100, 9'd15, 9'd0);
    step_to(gray_pos - 1);
    step_to(gray_pos - 1);

    // random part: mostly steady rotation, out past the wrap and back
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        apply_settings(9'd255, 9'd255, 9'd255, 9'd255, 9'd15, 9'd127);
      else if (ph == 1)
        apply_settings(9'd0, 9'd0, 9'd0, 9'h100, 9'd0, 9'd0);
      else
        apply_settings(pick_setting(REG_KP), pick_setting(REG_KI), pick_setting(REG_KD),
                       pick_setting(REG_TARGET), pick_setting(REG_SCALE),
                       pick_setting(REG_LIMIT));
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 86) next_pos = gray_pos + heading;
        else if (pick < 91) next_pos = gray_pos - heading;
        else if (pick < 95) next_pos = gray_pos;
        else next_pos = $urandom_range(0, 3);
        step_to(next_pos);
        if (heading > 0 && tally >= TRAVEL_TOP) heading = -1;
        else if (heading < 0 && tally <= 0) heading = 1;
      end
    end

    // drain
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("summary: %0d encoder words under %0d register settings",
             words_sent, settings_done);
    $display("summary: peak net travel %0d counts, position wraps past %0d",
             peak, COUNT_HALF);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/eapmd_pkg.sv
sv/encoder_angle_pid_motor_drive_core.sv
sv/eapmd_checker.sv
bench/drive_checker.sv
bench/testbench.sv
